FILE: sv/rbpc_pkg.sv
// Shared types and constants for the repeated block pair counter.
package rbpc_pkg;

  localparam int MAX_BLOCKS_DEFAULT = 256;
  localparam int PAIR_W = 15;
  localparam logic [PAIR_W-1:0] PAIR_LIMIT = {PAIR_W{1'b1}};

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        last_block;
  } in_word_t;

  typedef struct packed {
    logic [PAIR_W-1:0] pair_count;
    logic              ecb_detected;
    logic              overflow;
  } out_word_t;

  // A block travelling down the cell row.
  typedef struct packed {
    logic        valid;
    logic        last;
    logic        placed;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } token_t;

endpackage

FILE: sv/rbpc_cell.sv
// One cell of the row: holds one stored block and compares every passing block with it.
module rbpc_cell
  import rbpc_pkg::*;
#(
  parameter int CW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  token_t        tok_in,
  input  logic [CW-1:0] cnt_in,
  output token_t        tok_out,
  output logic [CW-1:0] cnt_out
);

  logic        held;
  logic [63:0] kept_high;
  logic [63:0] kept_low;
  logic        match;
  logic        take;

  assign match = held && (kept_high == tok_in.block_high) && (kept_low == tok_in.block_low);
  // The first empty cell a non-final block meets is where it is stored.
  assign take  = tok_in.valid && !held && !tok_in.placed && !tok_in.last;

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_out.last       <= tok_in.last;
      tok_out.placed     <= tok_in.placed || !held;
      tok_out.block_high <= tok_in.block_high;
      tok_out.block_low  <= tok_in.block_low;
      cnt_out            <= cnt_in + CW'(match);
      if (take) begin
        kept_high <= tok_in.block_high;
        kept_low  <= tok_in.block_low;
      end
    end
    if (rst) begin
      held          <= 1'b0;
      tok_out.valid <= 1'b0;
    end else if (adv) begin
      tok_out.valid <= tok_in.valid;
      if (tok_in.valid && tok_in.last) begin
        held <= 1'b0;
      end else if (take) begin
        held <= 1'b1;
      end
    end
  end

endmodule

FILE: sv/rbpc_accum.sv
// End of the row: running pair total, overflow flag and the output register.
module rbpc_accum
  import rbpc_pkg::*;
#(
  parameter int CW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  token_t        tok,
  input  logic [CW-1:0] cnt,
  output logic          adv,
  output logic          out_valid,
  input  logic          out_ready,
  output out_word_t     out_word
);

  logic [PAIR_W-1:0] pair_total;
  logic              overflow_seen;
  logic [PAIR_W:0]   sum;
  logic [PAIR_W-1:0] sum_sat;
  logic [CW-1:0]     add;
  logic              ovf;

  // The row moves unless a final word would land on a result not yet taken.
  assign adv = !(tok.valid && tok.last && out_valid && !out_ready);

  // A block that found no empty cell met a full store, so its matches do not count.
  assign add     = tok.placed ? cnt : '0;
  assign sum     = {1'b0, pair_total} + (PAIR_W+1)'(add);
  assign sum_sat = sum[PAIR_W] ? PAIR_LIMIT : sum[PAIR_W-1:0];
  assign ovf     = overflow_seen || !tok.placed;

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_total    <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (adv && tok.valid && tok.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (adv && tok.valid) begin
        if (tok.last) begin
          pair_total    <= '0;
          overflow_seen <= 1'b0;
        end else begin
          pair_total    <= sum_sat;
          overflow_seen <= ovf;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tok.valid && tok.last) begin
      out_word.pair_count   <= sum_sat;
      out_word.ecb_detected <= (sum_sat != '0);
      out_word.overflow     <= ovf;
    end
  end

endmodule

FILE: sv/repeated_block_pair_counter_top.sv
// Top level of the repeated block pair counter: a row of comparing cells and the result stage.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_ready    | in_word  (in_word_t)
//   out     | output    | out_valid / out_ready  | out_word (out_word_t)
//
// One word is taken every cycle unless the row stalls; each word walks the row of MAX_BLOCKS
// cells, one cell per advancing cycle, and the final word's result is registered at the row's end.
// Each cell holds one stored block; a final word empties every cell it passes.
// Reset clears all valid flags, the pair total and the overflow flag.
// The whole row stalls only while a final word waits on a result not yet taken.
module repeated_block_pair_counter_top
  import rbpc_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  localparam int CW = $clog2(MAX_BLOCKS + 1);

  token_t        tok [0:MAX_BLOCKS];
  logic [CW-1:0] cnt [0:MAX_BLOCKS];
  logic          adv;

  assign in_ready = adv;

  always_comb begin
    tok[0].valid      = in_valid;
    tok[0].last       = in_word.last_block;
    tok[0].placed     = 1'b0;
    tok[0].block_high = in_word.block_high;
    tok[0].block_low  = in_word.block_low;
    cnt[0]            = '0;
  end

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    rbpc_cell #(.CW(CW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .tok_in  (tok[i]),
      .cnt_in  (cnt[i]),
      .tok_out (tok[i+1]),
      .cnt_out (cnt[i+1])
    );
  end

  rbpc_accum #(.CW(CW)) u_accum (
    .clk       (clk),
    .rst       (rst),
    .tok       (tok[MAX_BLOCKS]),
    .cnt       (cnt[MAX_BLOCKS]),
    .adv       (adv),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

FILE: sv/rbpc_checker.sv
// Port-level checks for the repeated block pair counter, bound to the top level.
module rbpc_checker
  import rbpc_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_word
);

  // A word offered on the input stays put until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_word))
    else $error("input word changed while stalled");

  // A result waiting on the output holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // The verdict follows the pair count.
  a_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.ecb_detected == (out_word.pair_count != '0)))
    else $error("verdict does not match pair count");

  // Input is refused only while a result is held back by the consumer.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input refused without output stall");

endmodule

bind repeated_block_pair_counter_top rbpc_checker u_rbpc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

FILE: tb/rbpc_checker.sv
// Scoreboard for the repeated block pair counter: predicts every verdict and checks it.
`timescale 1ns / 100ps

module rbpc_scoreboard
  import rbpc_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_word,
  output int        fail_count,
  output int        pending,
  output int        verdicts_checked,
  output int        ecb_verdicts,
  output int        overflow_verdicts
);

  // Model of the message currently being collected.
  logic [63:0] held_high [MAX_BLOCKS];
  logic [63:0] held_low  [MAX_BLOCKS];
  int          held_count;
  int          pair_sum;
  logic        store_overflowed;

  out_word_t   expected_verdicts [$];
  int          mismatches = 0;
  int          checked = 0;
  int          ecb_count = 0;
  int          overflow_count = 0;

  task automatic tally_block(input in_word_t w);
    int        hits;
    out_word_t verdict;
    if (held_count < MAX_BLOCKS) begin
      hits = 0;
      for (int k = 0; k < held_count; k++) begin
        if (held_high[k] == w.block_high && held_low[k] == w.block_low) hits++;
      end
      pair_sum = pair_sum + hits;
      if (pair_sum > int'(PAIR_LIMIT)) pair_sum = int'(PAIR_LIMIT);
      held_high[held_count] = w.block_high;
      held_low[held_count] = w.block_low;
      held_count++;
    end else begin
      // The store is full, so the word is neither compared nor kept.
      store_overflowed = 1'b1;
    end
    if (w.last_block) begin
      verdict.pair_count = pair_sum[PAIR_W-1:0];
      verdict.ecb_detected = (pair_sum > 0);
      verdict.overflow = store_overflowed;
      expected_verdicts.push_back(verdict);
      held_count = 0;
      pair_sum = 0;
      store_overflowed = 1'b0;
    end
  endtask

  task automatic check_verdict(input out_word_t got);
    out_word_t want;
    if (expected_verdicts.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result pairs=%0d ecb=%0b overflow=%0b", $time,
                 got.pair_count, got.ecb_detected, got.overflow);
    end else begin
      want = expected_verdicts.pop_front();
      checked++;
      if (want.ecb_detected) ecb_count++;
      if (want.overflow) overflow_count++;
      if (got.pair_count !== want.pair_count || got.ecb_detected !== want.ecb_detected ||
          got.overflow !== want.overflow) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: mismatch, expected pairs=%0d ecb=%0b overflow=%0b, ",
                    "got pairs=%0d ecb=%0b overflow=%0b"},
                   $time, want.pair_count, want.ecb_detected, want.overflow,
                   got.pair_count, got.ecb_detected, got.overflow);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held_count = 0;
      pair_sum = 0;
      store_overflowed = 1'b0;
      expected_verdicts.delete();
    end else begin
      if (out_valid && out_ready) check_verdict(out_word);
      if (in_valid && in_ready) tally_block(in_word);
    end
    pending <= expected_verdicts.size();
    fail_count <= mismatches;
    verdicts_checked <= checked;
    ecb_verdicts <= ecb_count;
    overflow_verdicts <= overflow_count;
  end

endmodule

FILE: tb/tb_top.sv
// Testbench top for the repeated block pair counter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top
  import rbpc_pkg::*;
();

  localparam int MAX_BLOCKS = MAX_BLOCKS_DEFAULT;
  localparam int RANDOM_WORDS_PER_PHASE = 578;
  // Longest correct quiet spell is a result crossing the whole cell row while the
  // receiver stalls; this leaves a wide margin over that.
  localparam int STALL_LIMIT = 20 * (MAX_BLOCKS + 1);
  localparam logic [63:0] ONES = {64{1'b1}};

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  int fail_count;
  int pending;
  int verdicts_checked;
  int ecb_verdicts;
  int overflow_verdicts;

  int words_sent = 0;
  int messages_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  int send_idle_by_phase [3] = '{12, 49, 0};
  int recv_idle_by_phase [3] = '{49, 12, 0};
  int long_len_by_phase  [3] = '{MAX_BLOCKS, MAX_BLOCKS + 1, MAX_BLOCKS + 9};
  int long_pool_by_phase [3] = '{1, 4, 6};
  int long_reuse_by_phase[3] = '{100, 50, 40};

  repeated_block_pair_counter_top #(.MAX_BLOCKS(MAX_BLOCKS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
  );

  rbpc_scoreboard #(.MAX_BLOCKS(MAX_BLOCKS)) verdict_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .fail_count(fail_count), .pending(pending), .verdicts_checked(verdicts_checked),
    .ecb_verdicts(ecb_verdicts), .overflow_verdicts(overflow_verdicts)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  // Valid stays high between words unless an idle gap is drawn.
  task automatic push_word(input logic [63:0] high_half, input logic [63:0] low_half,
                           input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= '{block_high: high_half, block_low: low_half, last_block: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
    if (last) messages_sent++;
  endtask

  // A message drawn from a small pool of blocks, with near copies and fresh blocks.
  task automatic send_message(input int length, input int pool_size, input int reuse_pct);
    logic [127:0] pool [8];
    logic [127:0] blk;
    int           pick;
    for (int p = 0; p < 8; p++) pool[p] = {$urandom, $urandom, $urandom, $urandom};
    for (int n = 1; n <= length; n++) begin
      pick = $urandom_range(99);
      blk = pool[$urandom_range(pool_size - 1)];
      if (pick >= reuse_pct + (100 - reuse_pct) / 3)
        blk = {$urandom, $urandom, $urandom, $urandom};
      else if (pick >= reuse_pct)
        blk = blk ^ (128'd1 << $urandom_range(127));
      push_word(blk[127:64], blk[63:0], n == length);
    end
  endtask

  initial begin
    int phase_start;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Single-block messages at both extremes of the data.
    push_word(64'd0, 64'd0, 1'b1);
    push_word(ONES, ONES, 1'b1);
    // One identical pair.
    push_word(ONES, ONES, 1'b0);
    push_word(ONES, ONES, 1'b1);
    // Near misses in either half; only the first and last blocks match.
    push_word(64'd0, 64'd0, 1'b0);
    push_word(64'd0, 64'h8000_0000_0000_0000, 1'b0);
    push_word(64'd1, 64'd0, 1'b0);
    push_word(64'd0, 64'd0, 1'b1);
    // Four equal blocks give six pairs.
    repeat (3) push_word(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    push_word(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    // Alternating blocks give two pairs.
    push_word(64'hAAAA_AAAA_AAAA_AAAA, 64'h0123_4567_89AB_CDEF, 1'b0);
    push_word(64'h5555_5555_5555_5555, 64'hFEDC_BA98_7654_3210, 1'b0);
    push_word(64'hAAAA_AAAA_AAAA_AAAA, 64'h0123_4567_89AB_CDEF, 1'b0);
    push_word(64'h5555_5555_5555_5555, 64'hFEDC_BA98_7654_3210, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = send_idle_by_phase[phase];
      recv_idle_pct = recv_idle_by_phase[phase];
      phase_start = words_sent;
      // One long message per phase: a full store of equal blocks first, then longer mixed ones that overflow.
      send_message(long_len_by_phase[phase], long_pool_by_phase[phase],
                   long_reuse_by_phase[phase]);
      while (words_sent - phase_start < RANDOM_WORDS_PER_PHASE) begin
        send_message(($urandom_range(99) < 70) ? $urandom_range(1, 6) : $urandom_range(7, 32),
                     $urandom_range(1, 8), $urandom_range(0, 80));
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (MAX_BLOCKS + 10) @(posedge clk);

    $display("Sent %0d words in %0d messages, three idle patterns, store of %0d blocks.",
             words_sent, messages_sent, MAX_BLOCKS);
    $display("Checked %0d verdicts: %0d ECB, %0d with overflow.",
             verdicts_checked, ecb_verdicts, overflow_verdicts);
    if (fail_count == 0 && pending == 0) begin
      $display("repeated_block_pair_counter_top regression: pass");
    end else begin
      $display("repeated_block_pair_counter_top regression: fail");
    end
    $finish;
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
    $display("repeated_block_pair_counter_top regression: fail");
    $finish;
  end

endmodule
